FILE: rtl/lpht_pkg.sv
// Package: shared types, constants and layer geometry for the layered hash table.
package lpht_pkg;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_GET    = 2'd2,
    REQ_GET_ALT = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_HIT      = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_MISSING  = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CLEAR = 2'd1,
    PH_READ = 2'd2,
    PH_WRITE = 2'd3
  } phase_t;

  localparam int unsigned GROW_STEP = 257;

  // Next layer size along the prime ladder up to 101; 33 maps to 37, and any other size grows by GROW_STEP.
  function automatic int unsigned next_size(input int unsigned s);
    int unsigned r;
    case (s)
      2: r = 3;
      3: r = 5;
      5: r = 7;
      7: r = 11;
      11: r = 13;
      13: r = 17;
      17: r = 19;
      19: r = 23;
      23: r = 29;
      29: r = 31;
      31: r = 37;
      33: r = 37;
      37: r = 41;
      41: r = 43;
      43: r = 47;
      47: r = 53;
      53: r = 59;
      59: r = 61;
      61: r = 67;
      67: r = 71;
      71: r = 73;
      73: r = 79;
      79: r = 83;
      83: r = 89;
      89: r = 97;
      97: r = 101;
      default: r = s + GROW_STEP;
    endcase
    return r;
  endfunction

  function automatic int unsigned layer_size(input int unsigned first, input int unsigned k);
    int unsigned s;
    s = first;
    for (int unsigned i = 0; i < 16; i++) begin
      if (i < k) s = next_size(s);
    end
    return s;
  endfunction

endpackage

FILE: rtl/lpht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/lpht_slot_mod.sv
// Per-layer slot index: key modulo layer size by reciprocal multiplication and one correction.
module lpht_slot_mod #(
  parameter int KEY_WIDTH = 16,
  parameter int SIZE      = 5,
  parameter int IDX_W     = 3
) (
  input  logic                 clk,
  input  logic [KEY_WIDTH-1:0] key,
  output logic [IDX_W-1:0]     idx
);
  localparam int PROD_W = 2 * KEY_WIDTH;
  localparam int SZ_W   = $clog2(SIZE + 1);
  localparam int DIF_W  = KEY_WIDTH + SZ_W;
  // floor(2^KEY_WIDTH / SIZE): the quotient estimate is low by at most one.
  localparam logic [KEY_WIDTH-1:0] RECIP = KEY_WIDTH'((64'd1 << KEY_WIDTH) / SIZE);

  logic [PROD_W-1:0]    prod;
  logic [KEY_WIDTH-1:0] q_r;
  logic [DIF_W-1:0]     qn, dif, rem;

  assign prod = PROD_W'(key) * PROD_W'(RECIP);

  // Quotient estimate registered; key must hold for the next cycle.
  always_ff @(posedge clk) begin
    q_r <= prod[PROD_W-1 -: KEY_WIDTH];
  end

  assign qn  = DIF_W'(q_r) * DIF_W'(SIZE);
  assign dif = DIF_W'(key) - qn;
  assign rem = (dif >= DIF_W'(SIZE)) ? dif - DIF_W'(SIZE) : dif;

  assign idx = IDX_W'(rem);
endmodule

FILE: rtl/layered_prime_hash_table.sv
// Top level: layered direct-mapped key/value table with per-layer slot memories.
// Sequence: after input accept the reciprocal-multiply quotient is registered, then the
//   memory is read, then the write-back updates the memories and the result register.
// Flow: the next word is taken only after the result word has left, so out_tready stalls
//   delay the next word.
// Reset: synchronous active-low; then a clearing pass over slot indices below the max layer
//   size (29 by default) sweeps the valid bits of every layer before the first input word.
module layered_prime_hash_table #(
  parameter int MAX_LAYERS       = 8,
  parameter int FIRST_LAYER_SIZE = 5,
  parameter int KEY_WIDTH        = 16,
  parameter int VALUE_WIDTH      = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // req_type
  input  logic [55:0] in_tdata,   // [15:0] key, [47:16] value, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [2:0] status, [34:3] read_value, [37:35] layer_used
  output logic [2:0]  out_tuser   // unused flag space: zero
);
  localparam int LW      = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int ACT_W   = $clog2(MAX_LAYERS + 1);
  localparam int SIZE_MAX = lpht_pkg::layer_size(FIRST_LAYER_SIZE, MAX_LAYERS - 1);
  localparam int CLR_W   = $clog2(SIZE_MAX + 1);
  localparam int CNT_W   = 1;
  localparam int ENT_W   = 1 + KEY_WIDTH + VALUE_WIDTH;

  lpht_pkg::phase_t ph_r, ph_nxt;
  logic [CLR_W-1:0] clr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACT_W-1:0] act_r;
  lpht_pkg::req_t   req_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;

  // Result register.
  logic        ov_r;
  logic [2:0]  st_r;
  logic [31:0] rv_r;
  logic [2:0]  ly_r;

  logic accept;
  assign in_tready = (ph_r == lpht_pkg::PH_IDLE) && !ov_r;
  assign accept    = in_tvalid && in_tready;

  // Per-layer memories and modulo units.
  logic [ENT_W-1:0] rd  [MAX_LAYERS];
  logic [MAX_LAYERS-1:0] we;
  logic [MAX_LAYERS-1:0] v_hit, v_free;
  logic [ENT_W-1:0] wdata;
  logic [LW-1:0]    sel_l;

  for (genvar k = 0; k < MAX_LAYERS; k++) begin : g_layer
    localparam int SZ = lpht_pkg::layer_size(FIRST_LAYER_SIZE, k);
    localparam int IW = (SZ > 1) ? $clog2(SZ) : 1;
    logic [IW-1:0] idx, addr;
    lpht_slot_mod #(.KEY_WIDTH(KEY_WIDTH), .SIZE(SZ), .IDX_W(IW)) u_mod (
      .clk(clk), .key(key_r), .idx(idx));
    assign addr = (ph_r == lpht_pkg::PH_CLEAR) ? IW'(clr_r) : idx;
    lpht_ram #(.WIDTH(ENT_W), .DEPTH(SZ)) u_ram (
      .clk(clk),
      .we(((ph_r == lpht_pkg::PH_CLEAR) && (32'(clr_r) < SZ)) || we[k]),
      .waddr(addr),
      .wdata((ph_r == lpht_pkg::PH_CLEAR) ? '0 : wdata),
      .raddr(addr),
      .rdata(rd[k]));
    assign v_hit[k]  = (k < act_r) && rd[k][ENT_W-1] &&
                       (rd[k][ENT_W-2 -: KEY_WIDTH] == key_r);
    assign v_free[k] = (k < act_r) && !rd[k][ENT_W-1];
  end

  // Oldest-first priority pick over the probed layers.
  logic         any_hit, any_free;
  logic [LW-1:0] hit_l, free_l;
  always_comb begin
    any_hit = 1'b0; any_free = 1'b0; hit_l = '0; free_l = '0;
    for (int k = MAX_LAYERS - 1; k >= 0; k--) begin
      if (v_hit[k])  begin any_hit = 1'b1;  hit_l  = LW'(k); end
      if (v_free[k]) begin any_free = 1'b1; free_l = LW'(k); end
    end
  end

  // Write-back decision, made in the write phase from registered read data.
  logic [2:0]  st_nxt;
  logic [31:0] rv_nxt;
  logic [2:0]  ly_nxt;
  logic        grow;
  always_comb begin
    we = '0; wdata = '0; sel_l = '0; grow = 1'b0;
    st_nxt = lpht_pkg::ST_MISSING; rv_nxt = '0; ly_nxt = '0;
    case (req_r)
      lpht_pkg::REQ_SET: begin
        wdata = {1'b1, key_r, val_r};
        if (any_hit) begin
          sel_l = hit_l; st_nxt = lpht_pkg::ST_HIT; we[hit_l] = 1'b1;
        end else if (any_free) begin
          sel_l = free_l; st_nxt = lpht_pkg::ST_INSERTED; we[free_l] = 1'b1;
        end else if (32'(act_r) < MAX_LAYERS) begin
          sel_l = LW'(act_r); st_nxt = lpht_pkg::ST_INSERTED; we[sel_l] = 1'b1;
          grow = 1'b1;
        end else begin
          st_nxt = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::REQ_REMOVE: begin
        wdata = '0;
        if (any_hit) begin
          sel_l = hit_l; st_nxt = lpht_pkg::ST_REMOVED; we[hit_l] = 1'b1;
        end
      end
      default: begin
        if (any_hit) begin
          sel_l = hit_l; st_nxt = lpht_pkg::ST_HIT;
          rv_nxt = 32'(rd[hit_l][VALUE_WIDTH-1:0]);
        end
      end
    endcase
    if (st_nxt != lpht_pkg::ST_MISSING && st_nxt != lpht_pkg::ST_FULL) ly_nxt = 3'(sel_l);
    if (ph_r != lpht_pkg::PH_WRITE) we = '0;
  end

  // Phase sequencing.
  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      lpht_pkg::PH_CLEAR: if (32'(clr_r) == SIZE_MAX - 1) ph_nxt = lpht_pkg::PH_IDLE;
      lpht_pkg::PH_IDLE:  if (accept) ph_nxt = lpht_pkg::PH_READ;
      lpht_pkg::PH_READ:  if (cnt_r == '0) ph_nxt = lpht_pkg::PH_WRITE;
      lpht_pkg::PH_WRITE: ph_nxt = lpht_pkg::PH_IDLE;
      default:            ph_nxt = lpht_pkg::PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r  <= lpht_pkg::PH_CLEAR;
      clr_r <= '0;
      cnt_r <= '0;
      act_r <= ACT_W'(1);
      ov_r  <= 1'b0;
    end else begin
      ph_r <= ph_nxt;
      if (ph_r == lpht_pkg::PH_CLEAR) clr_r <= clr_r + 1'b1;
      // Read phase: the quotient is registered first, then the memory is read.
      if (accept) cnt_r <= 1'b1;
      else if (cnt_r != '0) cnt_r <= cnt_r - 1'b1;
      if (ph_r == lpht_pkg::PH_WRITE) begin
        ov_r <= 1'b1;
        if (grow) act_r <= act_r + 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= lpht_pkg::req_t'(in_tuser);
      key_r <= KEY_WIDTH'(in_tdata[15:0]);
      val_r <= VALUE_WIDTH'(in_tdata[47:16]);
    end
    if (ph_r == lpht_pkg::PH_WRITE) begin
      st_r <= st_nxt; rv_r <= rv_nxt; ly_r <= ly_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {2'b00, ly_r, rv_r, st_r};
  assign out_tuser  = '0;
endmodule

FILE: rtl/lpht_checker.sv
// Port-level checker for the layered hash table, bound to the top level.
module lpht_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= lpht_pkg::ST_FULL)
    else $error("status code out of range");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != lpht_pkg::ST_HIT |-> out_tdata[34:3] == 32'd0)
    else $error("read_value nonzero without a hit");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is in flight");
endmodule

bind layered_prime_hash_table lpht_checker u_lpht_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata));
